[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A plain property that must hold at every clock edge outside reset.
`define ESQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A same-cycle implication.
`define ESQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication.
`define ESQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/esq_pkg.sv]
// ----------------------------------------------------------------------------
// Elevator stop queue package
// Operation codes, direction codes, ordering classes and the control bundle
// that the sequencer sends along the row of queue cells.
// ----------------------------------------------------------------------------
package esq_pkg;

  localparam int OP_W    = 2;
  localparam int DIR_W   = 2;
  localparam int COUNT_W = 4;
  localparam int CLS_W   = 2;

  // Operation codes of a request.
  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // Travel direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // Ordering classes, most urgent first.
  localparam logic [CLS_W-1:0] CLS_HERE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_AHEAD  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BEHIND = 2'd2;
  localparam logic [CLS_W-1:0] CLS_EMPTY  = 2'd3;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic clear;    // empty every cell
    logic shift;    // every cell takes its right neighbour's value (pop head)
    logic add_new;  // the first empty cell takes the requested floor
    logic replace;  // the cell holding the floor takes the new floor
    logic rep_del;  // replacement removes the entry instead
    logic sort_en;  // one odd-even transposition pass
    logic phase;    // parity of the lower cell of each compared pair
  } esq_ctrl_t;

endpackage

[rtl/esq_if.sv]
// ----------------------------------------------------------------------------
// Elevator stop queue channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface esq_req_if
  import esq_pkg::*;
#(
  parameter int FLOOR_WIDTH = 8
) ();

  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [FLOOR_WIDTH-1:0] floor;
  logic [FLOOR_WIDTH-1:0] new_floor;

  modport source (output valid, output op, output floor, output new_floor, input ready);
  modport sink   (input valid, input op, input floor, input new_floor, output ready);

endinterface

interface esq_rsp_if
  import esq_pkg::*;
#(
  parameter int FLOOR_WIDTH = 8
) ();

  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [FLOOR_WIDTH-1:0] next_floor;
  logic [DIR_W-1:0]       direction;
  logic [COUNT_W-1:0]     pending_count;
  logic                   more_pending;

  modport source (output valid, output accepted, output next_floor, output direction,
                  output pending_count, output more_pending, input ready);
  modport sink   (input valid, input accepted, input next_floor, input direction,
                  input pending_count, input more_pending, output ready);

endinterface

[rtl/elevator_stop_queue_core.sv]
// ----------------------------------------------------------------------------
// Elevator stop queue core
// LOOK-ordered queue of pending floor requests built as a row of cells.
// ----------------------------------------------------------------------------
// Each request carries one operation (add, replace or remove, advance, clear)
// and gives exactly one response with the acceptance flag, the new head, the
// travel direction and the fill level. The queue lives in a row of
// QUEUE_DEPTH cells; after an operation that changes the entries, the row is
// re-ordered by QUEUE_DEPTH odd-even transposition passes, one a cycle, each
// cell comparing its ordering key with a neighbour's. A request that changes
// the entries therefore goes through accept, execute, the sort passes and
// response before the next acceptance, and one that does not (rejected,
// duplicate add, clear) skips the sort passes. One request is handled
// at a time; a finished response may wait in its output register while the
// next request is accepted. Reset empties the queue at once.
module elevator_stop_queue_core
  import esq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int FLOOR_WIDTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  esq_req_if.sink   req_if_i,
  esq_rsp_if.source rsp_if_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W = FLOOR_WIDTH + 2;
  localparam int PASS_W = $clog2(QUEUE_DEPTH);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [OP_W-1:0]        op_q;
  logic [FLOOR_WIDTH-1:0] floor_q;
  logic [FLOOR_WIDTH-1:0] new_floor_q;
  logic [FLOOR_WIDTH-1:0] cur_q, cur_d;
  logic [DIR_W-1:0]       dir_q, dir_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   acc_q, acc_d;
  logic                   upd_q, upd_d;
  logic [PASS_W-1:0]      pass_q;

  logic                   out_valid_q;
  logic                   out_acc_q;
  logic [FLOOR_WIDTH-1:0] out_next_q;
  logic [DIR_W-1:0]       out_dir_q;
  logic [CNT_W-1:0]       out_count_q;
  logic                   out_more_q;

  esq_ctrl_t              ctrl;
  logic                   need_sort;
  logic                   out_free;
  logic                   req_fire;

  logic [FLOOR_WIDTH-1:0] cell_val   [QUEUE_DEPTH];
  logic [KEY_W-1:0]       cell_key   [QUEUE_DEPTH];
  logic [FLOOR_WIDTH-1:0] left_val   [QUEUE_DEPTH];
  logic [KEY_W-1:0]       left_key   [QUEUE_DEPTH];
  logic [FLOOR_WIDTH-1:0] right_val  [QUEUE_DEPTH];
  logic [KEY_W-1:0]       right_key  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] left_busy;
  logic [QUEUE_DEPTH-1:0] hit_floor;
  logic [QUEUE_DEPTH-1:0] hit_new;

  logic [FLOOR_WIDTH-1:0] head;
  logic                   full;
  logic [DIR_W-1:0]       dir_fresh;

  // Row of cells with the neighbour links tied off at both ends.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g]  = '0;
      assign left_key[g]  = '0;
      assign left_busy[g] = 1'b1;
    end else begin : g_inner_left
      assign left_val[g]  = cell_val[g-1];
      assign left_key[g]  = cell_key[g-1];
      assign left_busy[g] = (cell_val[g-1] != '0);
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_val[g] = '0;
      assign right_key[g] = '1;
    end else begin : g_inner_right
      assign right_val[g] = cell_val[g+1];
      assign right_key[g] = cell_key[g+1];
    end

    esq_cell #(
      .FLOOR_WIDTH (FLOOR_WIDTH),
      .ODD         (1'(g % 2))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .floor_i     (floor_q),
      .new_floor_i (new_floor_q),
      .cur_floor_i (cur_q),
      .dir_down_i  (dir_q == DIR_DOWN),
      .left_val_i  (left_val[g]),
      .left_key_i  (left_key[g]),
      .left_busy_i (left_busy[g]),
      .right_val_i (right_val[g]),
      .right_key_i (right_key[g]),
      .val_o       (cell_val[g]),
      .key_o       (cell_key[g]),
      .hit_floor_o (hit_floor[g]),
      .hit_new_o   (hit_new[g])
    );
  end

  assign head     = cell_val[0];
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign req_fire = req_if_i.valid && req_if_i.ready;
  assign out_free = !out_valid_q || rsp_if_o.ready;

  // Direction from the head against the current floor.
  always_comb begin
    if ((head == '0) || (cur_q == '0) || (head == cur_q)) begin
      dir_fresh = DIR_STOP;
    end else if (head > cur_q) begin
      dir_fresh = DIR_UP;
    end else begin
      dir_fresh = DIR_DOWN;
    end
  end

  // Operation decode in the execute cycle, sort control afterwards.
  always_comb begin
    ctrl      = '0;
    need_sort = 1'b0;
    acc_d     = acc_q;
    upd_d     = upd_q;
    cur_d     = cur_q;
    dir_d     = dir_q;
    count_d   = count_q;
    if (state_q == ST_EXEC) begin
      acc_d = 1'b0;
      upd_d = 1'b0;
      case (op_q)
        OP_ADD: begin
          if (floor_q != '0) begin
            if (|hit_floor) begin
              acc_d = 1'b1;
            end else if (!full) begin
              acc_d        = 1'b1;
              ctrl.add_new = 1'b1;
              need_sort    = 1'b1;
              count_d      = count_q + CNT_W'(1);
            end
          end
        end
        OP_REPLACE: begin
          if ((floor_q != '0) && (|hit_floor)) begin
            acc_d        = 1'b1;
            ctrl.replace = 1'b1;
            ctrl.rep_del = (new_floor_q == '0) ||
                           ((new_floor_q != floor_q) && (|hit_new));
            need_sort    = 1'b1;
            if (ctrl.rep_del) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        OP_ADVANCE: begin
          if (head != '0) begin
            acc_d      = 1'b1;
            ctrl.shift = 1'b1;
            need_sort  = 1'b1;
            cur_d      = head;
            count_d    = count_q - CNT_W'(1);
          end
        end
        default: begin
          acc_d      = 1'b1;
          ctrl.clear = 1'b1;
          dir_d      = DIR_STOP;
          count_d    = '0;
        end
      endcase
      upd_d = need_sort;
    end else if (state_q == ST_SORT) begin
      ctrl.sort_en = 1'b1;
      ctrl.phase   = pass_q[0];
    end else if ((state_q == ST_DONE) && out_free && upd_q) begin
      dir_d = dir_fresh;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = need_sort ? ST_SORT : ST_DONE;
      end
      ST_SORT: begin
        if (pass_q == PASS_W'(QUEUE_DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_if_i.ready = (state_q == ST_IDLE);

  // Control and queue state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      dir_q   <= DIR_STOP;
      count_q <= '0;
      acc_q   <= 1'b0;
      upd_q   <= 1'b0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      dir_q   <= dir_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      upd_q   <= upd_d;
      if (state_q == ST_SORT) begin
        pass_q <= pass_q + PASS_W'(1);
      end else begin
        pass_q <= '0;
      end
    end
  end

  // Captured request payload.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q        <= req_if_i.op;
      floor_q     <= req_if_i.floor;
      new_floor_q <= req_if_i.new_floor;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_if_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_acc_q   <= acc_q;
      out_next_q  <= head;
      out_dir_q   <= dir_d;
      out_count_q <= count_q;
      out_more_q  <= acc_q && (op_q == OP_ADVANCE) && (head != '0);
    end
  end

  assign rsp_if_o.valid        = out_valid_q;
  assign rsp_if_o.accepted     = out_acc_q;
  assign rsp_if_o.next_floor   = out_next_q;
  assign rsp_if_o.direction    = out_dir_q;
  assign rsp_if_o.more_pending = out_more_q;

  // Fill level reported modulo sixteen.
  if (CNT_W >= COUNT_W) begin : g_cnt_trunc
    assign rsp_if_o.pending_count = out_count_q[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign rsp_if_o.pending_count = {{(COUNT_W - CNT_W){1'b0}}, out_count_q};
  end

endmodule

[rtl/esq_cell.sv]
// ----------------------------------------------------------------------------
// Elevator stop queue cell
// Holds one pending floor, computes its ordering key against the current
// floor and exchanges its value with a neighbour during sort passes.
// ----------------------------------------------------------------------------
module esq_cell
  import esq_pkg::*;
#(
  parameter int FLOOR_WIDTH = 8,
  parameter bit ODD         = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esq_ctrl_t              ctrl_i,
  input  logic [FLOOR_WIDTH-1:0] floor_i,
  input  logic [FLOOR_WIDTH-1:0] new_floor_i,
  input  logic [FLOOR_WIDTH-1:0] cur_floor_i,
  input  logic                   dir_down_i,
  input  logic [FLOOR_WIDTH-1:0] left_val_i,
  input  logic [FLOOR_WIDTH+1:0] left_key_i,
  input  logic                   left_busy_i,
  input  logic [FLOOR_WIDTH-1:0] right_val_i,
  input  logic [FLOOR_WIDTH+1:0] right_key_i,
  output logic [FLOOR_WIDTH-1:0] val_o,
  output logic [FLOOR_WIDTH+1:0] key_o,
  output logic                   hit_floor_o,
  output logic                   hit_new_o
);

  logic [FLOOR_WIDTH-1:0] val_q, val_d;
  logic [FLOOR_WIDTH+1:0] key;
  logic                   above;
  logic                   fwd;
  logic [FLOOR_WIDTH-1:0] span;
  logic                   lower;

  // Ordering key: class in the top bits, distance from the current floor below.
  always_comb begin
    above = val_q > cur_floor_i;
    fwd   = dir_down_i ? !above : above;
    span  = above ? (val_q - cur_floor_i) : (cur_floor_i - val_q);
    if (val_q == '0) begin
      key = {CLS_EMPTY, {FLOOR_WIDTH{1'b0}}};
    end else if (val_q == cur_floor_i) begin
      key = {CLS_HERE, {FLOOR_WIDTH{1'b0}}};
    end else begin
      key = {(fwd ? CLS_AHEAD : CLS_BEHIND), span};
    end
  end

  // This cell is the lower one of its pair when the phase matches its parity.
  assign lower = (ctrl_i.phase == ODD);

  // Next value of the entry.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.clear) begin
      val_d = '0;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
    end else if (ctrl_i.add_new) begin
      if ((val_q == '0) && left_busy_i) begin
        val_d = floor_i;
      end
    end else if (ctrl_i.replace) begin
      if (hit_floor_o) begin
        val_d = ctrl_i.rep_del ? '0 : new_floor_i;
      end
    end else if (ctrl_i.sort_en) begin
      if (lower) begin
        if (key > right_key_i) begin
          val_d = right_val_i;
        end
      end else begin
        if (left_key_i > key) begin
          val_d = left_val_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o       = val_q;
  assign key_o       = key;
  assign hit_floor_o = (val_q == floor_i);
  assign hit_new_o   = (val_q == new_floor_i);

endmodule

[rtl/esq_checker.sv]
// ----------------------------------------------------------------------------
// Elevator stop queue checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esq_checker
  import esq_pkg::*;
#(
  parameter int FLOOR_WIDTH = 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic                   accepted_i,
  input logic [FLOOR_WIDTH-1:0] next_floor_i,
  input logic [DIR_W-1:0]       direction_i,
  input logic [COUNT_W-1:0]     pending_count_i,
  input logic                   more_pending_i
);

  // A stalled response keeps its contents.
  `ESQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(accepted_i) && $stable(next_floor_i) && $stable(direction_i) && $stable(pending_count_i) && $stable(more_pending_i), "response changed while stalled")

  // An empty queue reports no pending requests and no travel.
  `ESQ_ASSERT_IMPL(a_empty_stop, clk_i, rst_ni, rsp_valid_i && (next_floor_i == '0), (pending_count_i == '0) && (direction_i == DIR_STOP), "empty queue with count or direction")

  // More pending only after a successful advance that left a head.
  `ESQ_ASSERT_IMPL(a_more_head, clk_i, rst_ni, rsp_valid_i && more_pending_i, accepted_i && (next_floor_i != '0), "more pending without a head")

  // The reported direction is always one of the three defined codes.
  `ESQ_ASSERT_IMPL(a_dir_code, clk_i, rst_ni, rsp_valid_i, (direction_i == DIR_STOP) || (direction_i == DIR_UP) || (direction_i == DIR_DOWN), "undefined direction code")

  // Requests are taken one at a time.
  `ESQ_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken in back-to-back cycles")

endmodule

bind elevator_stop_queue_core esq_checker #(
  .FLOOR_WIDTH (FLOOR_WIDTH)
) u_esq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_if_i.valid),
  .req_ready_i     (req_if_i.ready),
  .rsp_valid_i     (rsp_if_o.valid),
  .rsp_ready_i     (rsp_if_o.ready),
  .accepted_i      (rsp_if_o.accepted),
  .next_floor_i    (rsp_if_o.next_floor),
  .direction_i     (rsp_if_o.direction),
  .pending_count_i (rsp_if_o.pending_count),
  .more_pending_i  (rsp_if_o.more_pending)
);

[dv/elevator_stop_queue_core_test.sv]
// ----------------------------------------------------------------------------
// Elevator stop queue core testbench
// Drives add, replace or remove, advance and clear requests into the core and
// checks every response against a LOOK-ordered queue kept in the scoreboard.
// A short directed sequence is followed by random traffic under three idling
// mixes, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module elevator_stop_queue_core_test;
  import esq_pkg::*;

  localparam int QDEPTH     = 8;
  localparam int FW         = 8;
  localparam int HALF_CYCLE = 6;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam int PHASE_REQS = 470;

  // One response as the core reports it.
  typedef struct packed {
    logic               accepted;
    logic [FW-1:0]      next_floor;
    logic [DIR_W-1:0]   direction;
    logic [COUNT_W-1:0] pending_count;
    logic               more_pending;
  } stop_reply_t;

  // Keeps its own copy of the stop queue and the responses still owed.
  class stop_queue_scoreboard;
    logic [FW-1:0]    stops [QDEPTH];
    logic [FW-1:0]    here;
    logic [DIR_W-1:0] heading;
    stop_reply_t      replies_due [$];
    int unsigned      failures;
    int unsigned      checked;
    int unsigned      op_seen [4];
    int unsigned      rejected;
    int unsigned      deepest;

    function new();
      foreach (stops[i]) stops[i] = '0;
      here    = '0;
      heading = DIR_STOP;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // Ordering key: class in the top bits, distance from the current floor below.
    function logic [CLS_W+FW-1:0] rank(logic [FW-1:0] v);
      logic          up_side;
      logic          ahead;
      logic [FW-1:0] gap;
      if (v == '0) return {CLS_EMPTY, {FW{1'b0}}};
      if (v == here) return {CLS_HERE, {FW{1'b0}}};
      up_side = v > here;
      ahead   = (heading == DIR_DOWN) ? !up_side : up_side;
      gap     = up_side ? v - here : here - v;
      return {ahead ? CLS_AHEAD : CLS_BEHIND, gap};
    endfunction

    // Compacts the queue and puts it in LOOK order by insertion.
    function void resort();
      logic [FW-1:0] row [QDEPTH];
      logic [FW-1:0] v;
      int            n;
      int            j;
      n = 0;
      for (int i = 0; i < QDEPTH; i++) begin
        if (stops[i] != '0) begin
          row[n] = stops[i];
          n++;
        end
      end
      for (int i = 1; i < n; i++) begin
        v = row[i];
        j = i - 1;
        while (j >= 0 && rank(row[j]) > rank(v)) begin
          row[j + 1] = row[j];
          j--;
        end
        row[j + 1] = v;
      end
      for (int i = 0; i < QDEPTH; i++) stops[i] = (i < n) ? row[i] : '0;
    endfunction

    function void refresh_heading();
      if (stops[0] == '0 || here == '0 || stops[0] == here) begin
        heading = DIR_STOP;
      end else begin
        heading = (stops[0] > here) ? DIR_UP : DIR_DOWN;
      end
    endfunction

    function int locate(logic [FW-1:0] v);
      for (int i = 0; i < QDEPTH; i++) if (stops[i] == v) return i;
      return -1;
    endfunction

    function int fill();
      int n;
      n = 0;
      foreach (stops[i]) if (stops[i] != '0) n++;
      return n;
    endfunction

    // Applies an accepted request and queues the response it must produce.
    function void note_request(logic [OP_W-1:0] op, logic [FW-1:0] f, logic [FW-1:0] nf);
      stop_reply_t r;
      int          slot;
      r = '0;
      case (op)
        OP_ADD: begin
          if (f != '0) begin
            if (locate(f) >= 0) begin
              r.accepted = 1'b1;
            end else begin
              slot = locate('0);
              if (slot >= 0) begin
                stops[slot] = f;
                resort();
                refresh_heading();
                r.accepted = 1'b1;
              end
            end
          end
        end
        OP_REPLACE: begin
          slot = (f != '0) ? locate(f) : -1;
          if (slot >= 0) begin
            // A new floor that is already pending merges into that entry.
            if (nf == '0 || (nf != f && locate(nf) >= 0)) stops[slot] = '0;
            else stops[slot] = nf;
            resort();
            refresh_heading();
            r.accepted = 1'b1;
          end
        end
        OP_ADVANCE: begin
          if (stops[0] != '0) begin
            here     = stops[0];
            stops[0] = '0;
            resort();
            refresh_heading();
            r.accepted     = 1'b1;
            r.more_pending = stops[0] != '0;
          end
        end
        default: begin
          foreach (stops[i]) stops[i] = '0;
          heading    = DIR_STOP;
          r.accepted = 1'b1;
        end
      endcase
      r.next_floor    = stops[0];
      r.direction     = heading;
      r.pending_count = COUNT_W'(fill());
      op_seen[op]++;
      if (!r.accepted) rejected++;
      if (fill() > deepest) deepest = fill();
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_response(stop_reply_t got);
      stop_reply_t want;
      if (replies_due.size() == 0) begin
        $error("response arrived with no request outstanding");
        failures++;
        return;
      end
      want = replies_due.pop_front();
      checked++;
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("next_floor", want.next_floor, got.next_floor);
      compare_field("direction", want.direction, got.direction);
      compare_field("pending_count", want.pending_count, got.pending_count);
      compare_field("more_pending", want.more_pending, got.more_pending);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_armed;
  int   quiet_cycles;

  stop_queue_scoreboard board;

  esq_req_if #(.FLOOR_WIDTH(FW)) req_if ();
  esq_rsp_if #(.FLOOR_WIDTH(FW)) rsp_if ();

  elevator_stop_queue_core #(
    .QUEUE_DEPTH(QDEPTH),
    .FLOOR_WIDTH(FW)
  ) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_if_i(req_if),
    .rsp_if_o(rsp_if)
  );

  initial clk = 1'b0;
  always #HALF_CYCLE clk = ~clk;

  // Offers one request, idling first at random, and holds it until taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [FW-1:0] f,
                              input logic [FW-1:0] nf);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) >= send_idle_pct) break;
      req_if.valid <= 1'b0;
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.floor     <= f;
    req_if.new_floor <= nf;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(op, f, nf);
  endtask

  function automatic logic [FW-1:0] pending_pick();
    int n;
    n = board.fill();
    if (n == 0) return FW'($urandom_range(1, 16));
    return board.stops[$urandom_range(n - 1)];
  endfunction

  // Mostly low floors so that duplicates and a full queue come up often.
  function automatic logic [FW-1:0] floor_pick();
    int k;
    k = $urandom_range(99);
    if (k < 3) return '0;
    if (k < 50) return FW'($urandom_range(1, 16));
    if (k < 70) return pending_pick();
    return FW'($urandom_range(1, 255));
  endfunction

  task automatic random_request();
    int            k;
    logic [FW-1:0] f;
    logic [FW-1:0] nf;
    k  = $urandom_range(99);
    f  = floor_pick();
    nf = FW'($urandom_range(255));
    if (k < 44) begin
      send_request(OP_ADD, f, nf);
    end else if (k < 66) begin
      if ($urandom_range(99) < 75) f = pending_pick();
      case ($urandom_range(9))
        0, 1:    nf = '0;
        2, 3, 4: nf = pending_pick();
        5:       nf = f;
        default: nf = floor_pick();
      endcase
      send_request(OP_REPLACE, f, nf);
    end else if (k < 96) begin
      send_request(OP_ADVANCE, f, nf);
    end else begin
      send_request(OP_CLEAR, f, nf);
    end
  endtask

  // Response side: random back-pressure, plus one long hold-off when armed.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every response taken is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      board.check_response({rsp_if.accepted, rsp_if.next_floor, rsp_if.direction,
                            rsp_if.pending_count, rsp_if.more_pending});
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("** elevator_stop_queue_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    board            = new();
    hold_armed       = 1'b0;
    send_idle_pct    = 6;
    recv_idle_pct    = 73;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.op        = OP_ADD;
    req_if.floor     = '0;
    req_if.new_floor = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue rejects, extremes, fill to full, every replace case.
    send_request(OP_ADVANCE, 8'd0, 8'd0);
    send_request(OP_REPLACE, 8'd5, 8'd7);
    send_request(OP_ADD, 8'd0, 8'd255);
    send_request(OP_CLEAR, 8'd255, 8'd255);
    send_request(OP_ADD, 8'd255, 8'd0);
    send_request(OP_ADD, 8'd1, 8'd0);
    send_request(OP_ADD, 8'd1, 8'd0);
    send_request(OP_ADVANCE, 8'd0, 8'd0);
    send_request(OP_ADD, 8'd1, 8'd0);
    send_request(OP_ADD, 8'd128, 8'd0);
    send_request(OP_ADD, 8'd200, 8'd0);
    send_request(OP_ADD, 8'd170, 8'd0);
    send_request(OP_ADD, 8'd85, 8'd0);
    send_request(OP_ADD, 8'd2, 8'd0);
    send_request(OP_ADD, 8'd254, 8'd0);
    send_request(OP_ADD, 8'd33, 8'd0);
    send_request(OP_ADD, 8'd128, 8'd0);
    send_request(OP_REPLACE, 8'd0, 8'd9);
    send_request(OP_REPLACE, 8'd200, 8'd0);
    send_request(OP_REPLACE, 8'd170, 8'd128);
    send_request(OP_REPLACE, 8'd85, 8'd85);
    send_request(OP_REPLACE, 8'd254, 8'd3);
    send_request(OP_REPLACE, 8'd99, 8'd5);
    repeat (3) send_request(OP_ADVANCE, 8'd0, 8'd0);
    send_request(OP_CLEAR, 8'd0, 8'd0);
    send_request(OP_ADVANCE, 8'd0, 8'd0);

    // Random traffic under the three idling mixes.
    repeat (PHASE_REQS) random_request();
    send_idle_pct = 73;
    recv_idle_pct = 6;
    repeat (PHASE_REQS) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    repeat (PHASE_REQS) random_request();
    @(negedge clk);
    req_if.valid <= 1'b0;

    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d adds, %0d replaces, %0d advances, %0d clears; %0d rejected.",
             board.op_seen[OP_ADD], board.op_seen[OP_REPLACE], board.op_seen[OP_ADVANCE],
             board.op_seen[OP_CLEAR], board.rejected);
    $display("Checked %0d responses; queue reached %0d of %0d entries.",
             board.checked, board.deepest, QDEPTH);
    if (board.failures == 0 && board.replies_due.size() == 0) begin
      $display("** elevator_stop_queue_core: PASSED **");
    end else begin
      $display("** elevator_stop_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
